// File: hdl/ule_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ule_pkg
// Shared types and constants for the UART line editor: result kinds,
// register indexes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package ule_pkg;

    // Count field wide enough for the largest supported line capacity (64)
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 4;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_END = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ERASE    = CFG_IDX_W'(1);

    localparam logic [7:0] SPACE_BYTE     = 8'h20;
    localparam logic [7:0] LINE_END_RESET = 8'd13;
    localparam logic [7:0] ERASE_RESET    = 8'd8;

    typedef enum logic [1:0] {
        OP_STORE,   // echo, write into the line store
        OP_ERASE,   // echo erase, space, erase
        OP_FULL,    // echo, then flush the line
        OP_FLUSH    // flush the line
    } op_t;

    // cnt: write index for OP_STORE, line length for OP_FULL / OP_FLUSH
    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

endpackage

// File: hdl/ule_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ule_if
// Valid/ready channel interfaces: received bytes, results, register writes.
// ----------------------------------------------------------------------------
interface ule_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ule_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

interface ule_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ule_pkg::CFG_IDX_W-1:0]  index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/uart_line_editor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_editor_unit
// Canonical line editor for bytes received on a serial line: echo, erase,
// line store and line flush to the host.
// ----------------------------------------------------------------------------
//  channel | dir | transaction payload                 | handshake
//  --------+-----+-------------------------------------+-------------
//  rx      | in  | rx_byte[7:0]                        | valid/ready
//  result  | out | kind[1:0], data_byte[7:0], last     | valid/ready
//  cfg     | in  | index[3:0], data[7:0]               | valid/ready
//
//  Back-end results per transaction: ordinary byte, its echo; erase, erase,
//  space, erase; line end on an empty line, the marker; else a first store
//  read, then the line bytes and the marker; a full line echoes in the read step.
//  Unstalled flushes read the store's single port at one byte a cycle. Reset
//  clears control state only; the store is never cleared, as only entries
//  below the fill count are read. A four-entry command queue decouples stalls.
// ----------------------------------------------------------------------------
//
// Structure:
//   ule_front    - compares each byte with the control registers, keeps the
//                  fill count and turns the byte into a command.
//   ule_cmd_fifo - holds commands so the front keeps taking bytes while the
//                  back is still emitting an earlier flush.
//   ule_back     - owns the line store, writes stored bytes in command order
//                  (so a flush always sees every earlier write) and drives
//                  the registered result stage.
//
// The store holds at most LINE_CAPACITY-1 bytes; a byte arriving on a full
// line is echoed, dropped, and the line is flushed.
module uart_line_editor_unit #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ule_in_if.sink      rx,
    ule_out_if.source   result,
    ule_cfg_if.sink     cfg
);
    import ule_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    ule_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    ule_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    ule_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .result    (result)
    );

endmodule

// File: hdl/ule_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ule_front
// Accepts received bytes, classifies them against the configured control
// bytes, tracks the fill count and issues commands to the back end.
// ----------------------------------------------------------------------------
module ule_front #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    ule_in_if.sink          rx,
    ule_cfg_if.sink         cfg,
    output ule_pkg::cmd_t   cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);
    import ule_pkg::*;

    localparam int CW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] FILL_MAX = CW'(LINE_CAPACITY - 1);

    logic [7:0]    line_end_reg;
    logic [7:0]    erase_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          accept;

    assign cfg.ready = 1'b1;
    assign rx.ready  = cmd_ready;
    assign accept    = rx.valid && rx.ready;

    // Line end takes priority when both control bytes are equal
    always_comb
    begin
        fill_next = fill_reg;
        cmd_valid = 1'b0;
        cmd.op    = OP_STORE;
        cmd.data  = rx.rx_byte;
        cmd.cnt   = CNT_W'(fill_reg);
        if (rx.rx_byte == line_end_reg)
        begin
            cmd.op    = OP_FLUSH;
            cmd_valid = rx.valid;
            if (accept)
                fill_next = '0;
        end
        else if (rx.rx_byte == erase_reg)
        begin
            // erase on an empty line is swallowed without a command
            cmd.op    = OP_ERASE;
            cmd_valid = rx.valid && (fill_reg != '0);
            if (accept && (fill_reg != '0))
                fill_next = fill_reg - CW'(1);
        end
        else if (fill_reg < FILL_MAX)
        begin
            cmd.op    = OP_STORE;
            cmd_valid = rx.valid;
            if (accept)
                fill_next = fill_reg + CW'(1);
        end
        else
        begin
            cmd.op    = OP_FULL;
            cmd_valid = rx.valid;
            if (accept)
                fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            line_end_reg <= LINE_END_RESET;
            erase_reg    <= ERASE_RESET;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_LINE_END: line_end_reg <= cfg.data;
                    REG_ERASE:    erase_reg    <= cfg.data;
                    default:      ;
                endcase
            end
        end
    end

endmodule

// File: hdl/ule_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ule_cmd_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module ule_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  ule_pkg::cmd_t   push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ule_pkg::cmd_t   pop_cmd
);
    import ule_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    cmd_t          slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + NW'(1);
            else if (pop && !push)
                count_reg <= count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: hdl/ule_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ule_back
// Executes commands: holds the line store, sequences echoes and line flushes
// into a registered result stage.
// ----------------------------------------------------------------------------
module ule_back #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  ule_pkg::cmd_t   cmd,
    ule_out_if.source       result
);
    import ule_pkg::*;

    localparam int CW = $clog2(LINE_CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPACE,
        S_ERASE2,
        S_LINE,
        S_END
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    byte_reg, byte_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    data_reg, data_next;
    logic          last_reg, last_next;

    logic [7:0]    mem [LINE_CAPACITY];
    logic [7:0]    rd_data_reg;
    logic          out_free;
    logic          pop;
    logic          wr_en;
    logic [CW-1:0] cmd_cnt;
    logic [CW-1:0] ptr_inc;

    assign out_free  = !out_valid_reg || result.ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_cnt   = CW'(cmd.cnt);
    assign wr_en     = pop && (cmd.op == OP_STORE);
    assign ptr_inc   = ptr_reg + CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg && !result.ready;
        kind_next      = kind_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    byte_next = cmd.data;
                    cnt_next  = cmd_cnt;
                    ptr_next  = '0;
                    case (cmd.op)
                        OP_STORE:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_ECHO;
                            data_next      = cmd.data;
                            last_next      = 1'b1;
                        end
                        OP_ERASE:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_ECHO;
                            data_next      = cmd.data;
                            last_next      = 1'b0;
                            state_next     = S_SPACE;
                        end
                        OP_FULL:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_ECHO;
                            data_next      = cmd.data;
                            last_next      = 1'b0;
                            state_next     = (cmd_cnt == '0) ? S_END : S_LINE;
                        end
                        default:
                        begin
                            // flush: an empty line gives the end marker at once
                            if (cmd_cnt == '0)
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = KIND_END;
                                data_next      = '0;
                                last_next      = 1'b1;
                            end
                            else
                                state_next = S_LINE;
                        end
                    endcase
                end
            end
            S_SPACE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ECHO;
                    data_next      = SPACE_BYTE;
                    last_next      = 1'b0;
                    state_next     = S_ERASE2;
                end
            end
            S_ERASE2:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ECHO;
                    data_next      = byte_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LINE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_LINE;
                    data_next      = rd_data_reg;
                    last_next      = 1'b0;
                    ptr_next       = ptr_inc;
                    if (ptr_inc == cnt_reg)
                        state_next = S_END;
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_END;
                    data_next      = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    // Line store; the read follows the next pointer so its data is ready with the pointer
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cmd_cnt] <= cmd.data;
        rd_data_reg <= mem[ptr_next];
    end

    assign result.valid     = out_valid_reg;
    assign result.kind      = kind_reg;
    assign result.data_byte = data_reg;
    assign result.last      = last_reg;

endmodule

// File: hdl/ule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ule_checker
// Port-level checks on the result channel of the line editor.
// ----------------------------------------------------------------------------
module ule_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_kind,
    input logic [7:0] res_data_byte,
    input logic       res_last
);
    import ule_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind)
            && $stable(res_data_byte) && $stable(res_last))
        else $error("result changed while stalled");

    // the line-end marker always closes the item's results and carries zero
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_END) |-> res_last && (res_data_byte == 8'd0))
        else $error("line end without last or with data");

    // a line byte is never the final result
    a_line_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_LINE) |-> !res_last)
        else $error("line byte marked last");

    // after a line byte only more line bytes or the line end may follow
    a_line_seq: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && (res_kind == KIND_LINE) |=>
            !res_valid || (res_kind == KIND_LINE) || (res_kind == KIND_END))
        else $error("line flush interrupted");

endmodule

bind uart_line_editor_unit ule_checker u_ule_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_kind      (result.kind),
    .res_data_byte (result.data_byte),
    .res_last      (result.last)
);
